### rtl/lcs_pkg.sv
`default_nettype none
package lcs_pkg;

   localparam int MAX_RESULTS = 4;
   localparam int RES_IDX_W = 2;
   localparam int RES_CNT_W = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam logic [7:0] GATE_FULL = 8'd100;

   // Event codes.
   localparam logic [3:0] OP_VALVE_RPT  = 4'd0;
   localparam logic [3:0] OP_GATE_RPT   = 4'd1;
   localparam logic [3:0] OP_WATER_RPT  = 4'd2;
   localparam logic [3:0] OP_ENTER      = 4'd3;
   localparam logic [3:0] OP_EXIT       = 4'd4;
   localparam logic [3:0] OP_DIRECTION  = 4'd5;
   localparam logic [3:0] OP_EMERGENCY  = 4'd6;
   localparam logic [3:0] OP_END_EMERG  = 4'd7;
   localparam logic [3:0] OP_MANUAL     = 4'd8;
   localparam logic [3:0] OP_TAKE_MAN   = 4'd9;

   // Gate and valve states.
   localparam logic [2:0] ST_OPEN    = 3'd0;
   localparam logic [2:0] ST_CLOSED  = 3'd1;
   localparam logic [2:0] ST_OPENING = 3'd2;
   localparam logic [2:0] ST_CLOSING = 3'd3;
   localparam logic [2:0] ST_STOPPED = 3'd4;
   localparam logic [2:0] ST_ALERT   = 3'd5;

   // Water levels.
   localparam logic [1:0] LV_LOW  = 2'd0;
   localparam logic [1:0] LV_MID  = 2'd1;
   localparam logic [1:0] LV_HIGH = 2'd2;

   // Manual commands.
   localparam logic [2:0] MC_GATE_OPEN   = 3'd0;
   localparam logic [2:0] MC_GATE_CLOSE  = 3'd1;
   localparam logic [2:0] MC_GATE_STOP   = 3'd2;
   localparam logic [2:0] MC_VALVE_OPEN  = 3'd3;
   localparam logic [2:0] MC_VALVE_CLOSE = 3'd4;
   localparam logic [2:0] MC_GREEN       = 3'd5;
   localparam logic [2:0] MC_RED         = 3'd6;

   // Plant and display commands.
   localparam logic [3:0] C_ESTOP       = 4'd0;
   localparam logic [3:0] C_END_ESTOP   = 4'd1;
   localparam logic [3:0] C_OPEN_VALVE  = 4'd2;
   localparam logic [3:0] C_CLOSE_VALVE = 4'd3;
   localparam logic [3:0] C_OPEN_GATE   = 4'd4;
   localparam logic [3:0] C_CLOSE_GATE  = 4'd5;
   localparam logic [3:0] C_STOP_GATE   = 4'd6;
   localparam logic [3:0] C_RED         = 4'd7;
   localparam logic [3:0] C_GREEN       = 4'd8;
   localparam logic [3:0] C_SHOW_RED    = 4'd9;
   localparam logic [3:0] C_SHOW_GREEN  = 4'd10;
   localparam logic [3:0] C_SHOW_GATE   = 4'd11;
   localparam logic [3:0] C_SHOW_VALVE  = 4'd12;

   typedef struct packed {
      logic [3:0] op;
      logic       side;
      logic [2:0] reported_state;
      logic [6:0] gate_percent;
      logic [1:0] water_level;
      logic       direction;
      logic [2:0] manual_cmd;
   } event_type;

   typedef struct packed {
      logic [3:0] command;
      logic       cmd_side;
      logic [2:0] shown_state;
      logic [6:0] shown_percent;
   } result_type;

   // All results of one event, in order.
   typedef struct packed {
      logic [RES_CNT_W-1:0]           count;
      result_type [MAX_RESULTS-1:0]   items;
   } bundle_type;

   function automatic result_type mk_result(input logic [3:0] cmd, input logic sd,
                                            input logic [2:0] st, input logic [6:0] pct);
      result_type r;
      r.command       = cmd;
      r.cmd_side      = sd;
      r.shown_state   = st;
      r.shown_percent = pct;
      return r;
   endfunction

   function automatic bundle_type push_result(input bundle_type b, input result_type r);
      bundle_type o;
      o = b;
      if (b.count < RES_CNT_W'(MAX_RESULTS)) begin
         o.items[b.count[RES_IDX_W-1:0]] = r;
         o.count = b.count + RES_CNT_W'(1);
      end
      return o;
   endfunction

endpackage
`default_nettype wire

### rtl/lcs_front.sv
`default_nettype none
module lcs_front
   import lcs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       ev_valid,
   output logic            ev_ready,
   input  wire event_type  ev,
   input  wire logic       q_full,
   output logic            q_push,
   output bundle_type      q_bundle
);

   typedef enum logic [2:0] {
      SQ_IDLE       = 3'd0,
      SQ_VERIFY     = 3'd1,
      SQ_CLOSEOTHER = 3'd2,
      SQ_VALVES     = 3'd3,
      SQ_WAITWATER  = 3'd4,
      SQ_OPENGATE   = 3'd5
   } seq_step_type;

   logic [2:0]   upper_gate_ff, upper_gate_in, lower_gate_ff, lower_gate_in;
   logic [2:0]   upper_valve_ff, upper_valve_in, lower_valve_ff, lower_valve_in;
   logic [1:0]   level_ff, level_in;
   logic         emergency_ff, emergency_in;
   seq_step_type step_ff, step_in;
   logic         seq_side_ff, seq_side_in;
   logic         travel_dir_ff, travel_dir_in;

   logic         accept;
   bundle_type   bundle;

   assign ev_ready = !q_full;
   assign accept   = ev_valid && ev_ready;
   assign q_bundle = bundle;
   assign q_push   = accept && (bundle.count != '0);

   always_comb begin
      logic [2:0] st;
      logic       run;
      logic       go;
      logic       s;
      logic       o;
      logic [2:0] g;
      logic [2:0] v;
      logic [2:0] gs;
      logic [2:0] go_gate;
      logic       reached;
      logic       sd;

      upper_gate_in  = upper_gate_ff;
      lower_gate_in  = lower_gate_ff;
      upper_valve_in = upper_valve_ff;
      lower_valve_in = lower_valve_ff;
      level_in       = level_ff;
      emergency_in   = emergency_ff;
      step_in        = step_ff;
      seq_side_in    = seq_side_ff;
      travel_dir_in  = travel_dir_ff;
      bundle         = '0;
      run            = 1'b0;
      st             = ev.reported_state;
      sd             = ev.side;
      g              = sd ? lower_gate_ff : upper_gate_ff;
      v              = sd ? lower_valve_ff : upper_valve_ff;

      unique case (ev.op)
         OP_VALVE_RPT: begin
            if (sd) lower_valve_in = st;
            else    upper_valve_in = st;
            bundle = push_result(bundle, mk_result(C_SHOW_VALVE, sd, st, 7'd0));
         end
         OP_GATE_RPT: begin
            if (st != ST_ALERT) begin
               if ({1'b0, ev.gate_percent} == GATE_FULL) begin
                  st  = ST_OPEN;
                  run = (step_ff == SQ_OPENGATE);
               end else if (ev.gate_percent == 7'd0) begin
                  st  = ST_CLOSED;
                  run = (step_ff == SQ_CLOSEOTHER);
               end
            end
            if (sd) lower_gate_in = st;
            else    upper_gate_in = st;
            bundle = push_result(bundle, mk_result(C_SHOW_GATE, sd, st, ev.gate_percent));
         end
         OP_WATER_RPT: begin
            run = (ev.water_level == LV_HIGH || ev.water_level == LV_LOW)
                  && step_ff == SQ_WAITWATER;
            level_in = ev.water_level;
         end
         OP_ENTER, OP_EXIT: begin
            if (!emergency_ff && step_ff == SQ_IDLE) begin
               step_in     = SQ_VERIFY;
               seq_side_in = (ev.op == OP_ENTER) ? !travel_dir_ff : travel_dir_ff;
               run         = 1'b1;
            end
         end
         OP_DIRECTION: travel_dir_in = ev.direction;
         OP_EMERGENCY: begin
            if (!emergency_ff) begin
               bundle = push_result(bundle, mk_result(C_ESTOP, 1'b0, 3'd0, 7'd0));
               bundle = push_result(bundle, mk_result(C_SHOW_RED, 1'b0, ST_CLOSED, 7'd0));
               bundle = push_result(bundle, mk_result(C_SHOW_RED, 1'b1, ST_CLOSED, 7'd0));
               emergency_in = 1'b1;
               step_in      = SQ_IDLE;
            end
         end
         OP_END_EMERG: begin
            bundle = push_result(bundle, mk_result(C_END_ESTOP, 1'b0, 3'd0, 7'd0));
            emergency_in = 1'b0;
         end
         OP_MANUAL: begin
            if (!emergency_ff) begin
               unique case (ev.manual_cmd)
                  MC_GATE_OPEN:
                     if ((g == ST_CLOSED || g == ST_STOPPED)
                         && level_ff == (sd ? LV_LOW : LV_HIGH))
                        bundle = push_result(bundle, mk_result(C_OPEN_GATE, sd, 3'd0, 7'd0));
                  MC_GATE_CLOSE:
                     if (g != ST_CLOSED)
                        bundle = push_result(bundle, mk_result(C_CLOSE_GATE, sd, 3'd0, 7'd0));
                  MC_GATE_STOP:
                     if (g == ST_OPENING || g == ST_CLOSING)
                        bundle = push_result(bundle, mk_result(C_STOP_GATE, sd, 3'd0, 7'd0));
                  MC_VALVE_OPEN:
                     if (v == ST_CLOSED
                         && (sd ? upper_gate_ff : lower_gate_ff) == ST_CLOSED)
                        bundle = push_result(bundle, mk_result(C_OPEN_VALVE, sd, 3'd0, 7'd0));
                  MC_VALVE_CLOSE:
                     if (v == ST_OPEN)
                        bundle = push_result(bundle, mk_result(C_CLOSE_VALVE, sd, 3'd0, 7'd0));
                  MC_GREEN:
                     if (g == ST_OPEN) begin
                        bundle = push_result(bundle, mk_result(C_GREEN, sd, 3'd0, 7'd0));
                        bundle = push_result(bundle,
                                             mk_result(C_SHOW_GREEN, sd, ST_OPEN, 7'd0));
                     end
                  MC_RED: begin
                     bundle = push_result(bundle, mk_result(C_RED, sd, 3'd0, 7'd0));
                     bundle = push_result(bundle, mk_result(C_SHOW_RED, sd, ST_CLOSED, 7'd0));
                  end
                  default: ;
               endcase
            end
         end
         OP_TAKE_MAN: step_in = SQ_IDLE;
         default: ;
      endcase

      // One pass of the passage sequencer on the updated state; steps fall through
      // until one has to wait for the plant.
      s       = seq_side_in;
      o       = !s;
      gs      = s ? lower_gate_in : upper_gate_in;
      go_gate = o ? lower_gate_in : upper_gate_in;
      reached = s ? (level_in == LV_LOW) : (level_in == LV_HIGH);
      go      = run && !emergency_ff;
      if (go && step_in == SQ_VERIFY) begin
         if (gs == ST_OPEN) begin
            bundle  = push_result(bundle, mk_result(C_GREEN, s, 3'd0, 7'd0));
            bundle  = push_result(bundle, mk_result(C_SHOW_GREEN, s, ST_OPEN, 7'd0));
            step_in = SQ_IDLE;
            go      = 1'b0;
         end else begin
            step_in = SQ_CLOSEOTHER;
         end
      end
      if (go && step_in == SQ_CLOSEOTHER) begin
         if (go_gate != ST_CLOSED) begin
            bundle = push_result(bundle, mk_result(C_RED, o, 3'd0, 7'd0));
            bundle = push_result(bundle, mk_result(C_SHOW_RED, o, ST_CLOSED, 7'd0));
            bundle = push_result(bundle, mk_result(C_CLOSE_GATE, o, 3'd0, 7'd0));
            go     = 1'b0;
         end else begin
            step_in = SQ_VALVES;
         end
      end
      if (go && step_in == SQ_VALVES) begin
         if (!reached) begin
            if ((o ? lower_valve_in : upper_valve_in) == ST_OPEN)
               bundle = push_result(bundle, mk_result(C_CLOSE_VALVE, o, 3'd0, 7'd0));
            if ((s ? lower_valve_in : upper_valve_in) == ST_CLOSED)
               bundle = push_result(bundle, mk_result(C_OPEN_VALVE, s, 3'd0, 7'd0));
         end
         step_in = SQ_WAITWATER;
      end
      if (go && step_in == SQ_WAITWATER) begin
         if (!reached) go = 1'b0;
         else          step_in = SQ_OPENGATE;
      end
      if (go && step_in == SQ_OPENGATE) begin
         if (gs != ST_OPEN) begin
            bundle = push_result(bundle, mk_result(C_OPEN_GATE, s, 3'd0, 7'd0));
         end else begin
            bundle  = push_result(bundle, mk_result(C_GREEN, s, 3'd0, 7'd0));
            bundle  = push_result(bundle, mk_result(C_SHOW_GREEN, s, ST_OPEN, 7'd0));
            step_in = SQ_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_gate_ff  <= ST_CLOSED;
         lower_gate_ff  <= ST_CLOSED;
         upper_valve_ff <= ST_OPEN;
         lower_valve_ff <= ST_OPEN;
         level_ff       <= LV_MID;
         emergency_ff   <= 1'b0;
         step_ff        <= SQ_IDLE;
         seq_side_ff    <= 1'b0;
         travel_dir_ff  <= 1'b0;
      end else if (accept) begin
         upper_gate_ff  <= upper_gate_in;
         lower_gate_ff  <= lower_gate_in;
         upper_valve_ff <= upper_valve_in;
         lower_valve_ff <= lower_valve_in;
         level_ff       <= level_in;
         emergency_ff   <= emergency_in;
         step_ff        <= step_in;
         seq_side_ff    <= seq_side_in;
         travel_dir_ff  <= travel_dir_in;
      end
   end

   // No passage can be in progress during an emergency.
   a_emerg_idle: assert property (@(posedge clock) disable iff (reset)
      emergency_ff |-> step_ff == SQ_IDLE)
      else $error("sequencer active during emergency");

   // The emergency event always leaves the sequencer idle.
   a_emerg_stops: assert property (@(posedge clock) disable iff (reset)
      accept && ev.op == OP_EMERGENCY |=> emergency_ff && step_ff == SQ_IDLE)
      else $error("emergency did not stop the sequencer");

endmodule
`default_nettype wire

### rtl/lcs_queue.sv
`default_nettype none
module lcs_queue
   import lcs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire bundle_type  push_data,
   output logic             full,
   input  wire logic        pop,
   output logic             empty,
   output bundle_type       head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bundle_type    slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop)      count_in = count_ff + CW'(1);
      else if (pop && !push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from an empty queue");

endmodule
`default_nettype wire

### rtl/lcs_back.sv
`default_nettype none
module lcs_back
   import lcs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_empty,
   input  wire bundle_type q_head,
   output logic            q_pop,
   output logic            out_valid,
   input  wire logic       out_ready,
   output result_type      out_item,
   output logic            out_last
);

   logic [RES_IDX_W-1:0] idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   result_type           item_ff;
   logic                 last_ff;
   logic                 load;
   logic                 at_end;

   assign load   = (!valid_ff || out_ready) && !q_empty;
   assign at_end = (RES_CNT_W'(idx_ff) + RES_CNT_W'(1)) == q_head.count;
   assign q_pop  = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (out_ready) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_end ? '0 : idx_ff + RES_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= q_head.items[idx_ff];
         last_ff <= at_end;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_last  = last_ff;

   // The serializer position never runs past the results of the head event.
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> RES_CNT_W'(idx_ff) < q_head.count)
      else $error("result index beyond event result count");

endmodule
`default_nettype wire

### rtl/lock_chamber_sequencer_core.sv
`default_nettype none
// Canal-lock controller. Each request on req_ is one plant report, operator request,
// direction choice, emergency or manual event; the front end applies it to the
// gate, valve, water and sequencer state in the cycle it is accepted and forms all
// of its results (zero to four), which wait in a queue of QUEUE_DEPTH events.
// The back end sends them out on rsp_ one per cycle while rsp_tready is high, through
// an output register, with rsp_tlast on the final result of each event; events with no
// result produce nothing. A request is taken every cycle while the queue has room, and
// the output serializer sets the sustained rate.
module lock_chamber_sequencer_core
   import lcs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [3:0] op
   input  wire logic [3:0]  req_tuser,
   // [0] side, [3:1] reported_state, [10:4] gate_percent, [12:11] water_level,
   // [13] direction, [16:14] manual_cmd, [23:17] zero
   input  wire logic [23:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] command
   output logic [3:0]       rsp_tuser,
   // [0] cmd_side, [3:1] shown_state, [10:4] shown_percent, [15:11] zero
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast
);

   event_type  ev;
   logic       q_push, q_pop, q_full, q_empty;
   bundle_type push_bundle, head_bundle;
   result_type item;

   assign ev.op             = req_tuser;
   assign ev.side           = req_tdata[0];
   assign ev.reported_state = req_tdata[3:1];
   assign ev.gate_percent   = req_tdata[10:4];
   assign ev.water_level    = req_tdata[12:11];
   assign ev.direction      = req_tdata[13];
   assign ev.manual_cmd     = req_tdata[16:14];

   lcs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .ev_valid (req_tvalid),
      .ev_ready (req_tready),
      .ev       (ev),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_bundle (push_bundle)
   );

   lcs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_bundle),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (head_bundle)
   );

   lcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (head_bundle),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (item),
      .out_last  (rsp_tlast)
   );

   assign rsp_tuser = item.command;
   assign rsp_tdata = {5'd0, item.shown_percent, item.shown_state, item.cmd_side};

endmodule
`default_nettype wire
